>>> sv/uuid_text_codec_macros.svh
// ----------------------------------------------------------------------------
// uuid text codec assertion macros
// shared concurrent assertion forms, clocked on clk with async reset rst_n
// ----------------------------------------------------------------------------
`ifndef UUID_TEXT_CODEC_MACROS_SVH
`define UUID_TEXT_CODEC_MACROS_SVH

// same-cycle implication
`define UTC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define UTC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/utc_pkg.sv
// ----------------------------------------------------------------------------
// utc_pkg
// types, constants and character helpers of the uuid text codec
// ----------------------------------------------------------------------------
package utc_pkg;

    localparam int TEXT_LEN = 36;
    localparam int ID_W     = 128;
    localparam int NIB_CNT  = 32;
    localparam int POS_W    = 6;

    localparam logic [7:0] HYPHEN = 8'h2D;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(TEXT_LEN - 1);
    localparam logic [POS_W-1:0] END_POS  = POS_W'(TEXT_LEN);

    typedef enum logic [1:0] {
        OP_PARSE  = 2'd0,
        OP_FORMAT = 2'd1,
        OP_CLEAR  = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        CMD_END    = 2'd0,
        CMD_FORMAT = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t       kind;
        logic            ok;
        logic [ID_W-1:0] id;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    function automatic logic is_hyphen_pos(input logic [POS_W-1:0] p);
        return (p == 6'd8) || (p == 6'd13) || (p == 6'd18) || (p == 6'd23);
    endfunction

    // nibble index of a digit position
    function automatic logic [4:0] nib_index(input logic [POS_W-1:0] p);
        logic [POS_W-1:0] n;
        n = p - POS_W'(p > 6'd8) - POS_W'(p > 6'd13)
              - POS_W'(p > 6'd18) - POS_W'(p > 6'd23);
        return n[4:0];
    endfunction

    // bit 4 set when the character is not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = 5'(c - 8'h30);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            v = 5'(c - 8'h37);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            v = 5'(c - 8'h57);
        end
        else
        begin
            v = 5'd16;
        end
        return v;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] c;
        if (v < 4'd10)
        begin
            c = 8'h30 + {4'd0, v};
        end
        else
        begin
            c = 8'h57 + {4'd0, v};
        end
        return c;
    endfunction

endpackage

>>> sv/utc_front.sv
// ----------------------------------------------------------------------------
// utc_front
// accepts input words, tracks the parse in progress and queues commands
// ----------------------------------------------------------------------------
module utc_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // text_char
    input  logic [1:0]         s_axis_tuser,   // opcode
    input  logic               s_axis_tlast,   // char_last
    input  utc_pkg::fifo_stat_t fifo_stat,
    output logic               push,
    output utc_pkg::cmd_t      push_cmd
);
    import utc_pkg::*;

    logic [ID_W-1:0]  staging_reg, staging_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             err_reg, err_next;
    logic             accept;
    logic [4:0]       hex;
    logic [4:0]       nib;

    assign s_axis_tready = !fifo_stat.full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign hex           = hex_value(s_axis_tdata);
    assign nib           = nib_index(pos_reg);

    always_comb
    begin
        staging_next  = staging_reg;
        pos_next      = pos_reg;
        err_next      = err_reg;
        push          = 1'b0;
        push_cmd.kind = CMD_END;
        push_cmd.ok   = 1'b0;
        push_cmd.id   = '0;
        if (accept)
        begin
            case (opcode_t'(s_axis_tuser))
                OP_PARSE:
                begin
                    if (pos_reg >= END_POS)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        if (is_hyphen_pos(pos_reg))
                        begin
                            if (s_axis_tdata != HYPHEN && hex[4])
                            begin
                                err_next = 1'b1;
                            end
                        end
                        else if (hex[4])
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            for (int i = 0; i < NIB_CNT; i++)
                            begin
                                if (nib == 5'(i))
                                begin
                                    staging_next[ID_W-1-4*i -: 4] = hex[3:0];
                                end
                            end
                        end
                        pos_next = pos_reg + 1'b1;
                    end
                    if (s_axis_tlast)
                    begin
                        push          = 1'b1;
                        push_cmd.kind = CMD_END;
                        push_cmd.ok   = !err_next && (pos_next == END_POS);
                        push_cmd.id   = staging_next;
                        staging_next  = '0;
                        pos_next      = '0;
                        err_next      = 1'b0;
                    end
                end
                OP_FORMAT:
                begin
                    push          = 1'b1;
                    push_cmd.kind = CMD_FORMAT;
                end
                OP_CLEAR:
                begin
                    push          = 1'b1;
                    push_cmd.kind = CMD_CLEAR;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            staging_reg <= '0;
            pos_reg     <= '0;
            err_reg     <= 1'b0;
        end
        else
        begin
            staging_reg <= staging_next;
            pos_reg     <= pos_next;
            err_reg     <= err_next;
        end
    end

endmodule

>>> sv/utc_cmd_fifo.sv
// ----------------------------------------------------------------------------
// utc_cmd_fifo
// two-entry command queue between the front and back parts
// ----------------------------------------------------------------------------
module utc_cmd_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  utc_pkg::cmd_t       push_cmd,
    input  logic                pop,
    output utc_pkg::cmd_t       head_cmd,
    output utc_pkg::fifo_stat_t fifo_stat
);
    import utc_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;

    assign fifo_stat.full  = (cnt_reg == 2'd2);
    assign fifo_stat.empty = (cnt_reg == 2'd0);
    assign head_cmd        = entry_reg[rd_ptr_reg];
    assign do_push         = push && !fifo_stat.full;
    assign do_pop          = pop && !fifo_stat.empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        cnt_next    = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> sv/utc_back.sv
// ----------------------------------------------------------------------------
// utc_back
// holds the stored id, runs queued commands and drives the output register
// ----------------------------------------------------------------------------
module utc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  utc_pkg::cmd_t       head_cmd,
    input  utc_pkg::fifo_stat_t fifo_stat,
    output logic                pop,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [7:0]          m_axis_tdata,   // out_char
    output logic [2:0]          m_axis_tuser,   // parse_done, parse_ok, id_is_null
    output logic                m_axis_tlast    // out_last
);
    import utc_pkg::*;

    logic [ID_W-1:0]  stored_reg, stored_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             busy_reg, busy_next;
    logic             valid_reg, valid_next;
    logic [7:0]       char_reg, char_next;
    logic             last_reg, last_next;
    logic             done_reg, done_next;
    logic             ok_reg, ok_next;
    logic             null_reg, null_next;
    logic             load;
    logic [POS_W-1:0] fmt_pos;
    logic [4:0]       fmt_nib;
    logic [3:0]       fmt_val;
    logic [7:0]       fmt_char;

    assign load    = !valid_reg || m_axis_tready;
    assign fmt_pos = busy_reg ? pos_reg : '0;
    assign fmt_nib = nib_index(fmt_pos);

    always_comb
    begin
        fmt_val = '0;
        for (int i = 0; i < NIB_CNT; i++)
        begin
            if (fmt_nib == 5'(i))
            begin
                fmt_val = stored_reg[ID_W-1-4*i -: 4];
            end
        end
        fmt_char = is_hyphen_pos(fmt_pos) ? HYPHEN : hex_char(fmt_val);
    end

    always_comb
    begin
        stored_next = stored_reg;
        pos_next    = pos_reg;
        busy_next   = busy_reg;
        valid_next  = valid_reg;
        char_next   = char_reg;
        last_next   = last_reg;
        done_next   = done_reg;
        ok_next     = ok_reg;
        null_next   = null_reg;
        pop         = 1'b0;
        if (load)
        begin
            valid_next = 1'b0;
            if (busy_reg)
            begin
                valid_next = 1'b1;
                char_next  = fmt_char;
                last_next  = (pos_reg == LAST_POS);
                done_next  = 1'b0;
                ok_next    = 1'b0;
                null_next  = (stored_reg == '0);
                busy_next  = (pos_reg != LAST_POS);
                pos_next   = pos_reg + 1'b1;
            end
            else if (!fifo_stat.empty)
            begin
                pop = 1'b1;
                case (head_cmd.kind)
                    CMD_END:
                    begin
                        if (head_cmd.ok)
                        begin
                            stored_next = head_cmd.id;
                        end
                        valid_next = 1'b1;
                        char_next  = '0;
                        last_next  = 1'b1;
                        done_next  = 1'b1;
                        ok_next    = head_cmd.ok;
                        null_next  = (stored_next == '0);
                    end
                    CMD_FORMAT:
                    begin
                        valid_next = 1'b1;
                        char_next  = fmt_char;
                        last_next  = 1'b0;
                        done_next  = 1'b0;
                        ok_next    = 1'b0;
                        null_next  = (stored_reg == '0);
                        busy_next  = 1'b1;
                        pos_next   = POS_W'(1);
                    end
                    CMD_CLEAR:
                    begin
                        stored_next = '0;
                        valid_next  = 1'b1;
                        char_next   = '0;
                        last_next   = 1'b1;
                        done_next   = 1'b0;
                        ok_next     = 1'b0;
                        null_next   = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_reg <= '0;
            pos_reg    <= '0;
            busy_reg   <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            stored_reg <= stored_next;
            pos_reg    <= pos_next;
            busy_reg   <= busy_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
        done_reg <= done_next;
        ok_reg   <= ok_next;
        null_reg <= null_next;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = char_reg;
    assign m_axis_tlast  = last_reg;
    assign m_axis_tuser  = {null_reg, ok_reg, done_reg};

endmodule

>>> sv/uuid_text_codec.sv
// ----------------------------------------------------------------------------
// uuid_text_codec
// parses and formats the 36-character canonical text form of a 128-bit id
// ----------------------------------------------------------------------------
// channel   dir  tdata       tuser                            tlast
// s_axis    in   text_char   opcode                           char_last
// m_axis    out  out_char    parse_done, parse_ok, id_is_null out_last
//
// one input word per cycle while the command queue is not full
// parse end and clear give one output word; format gives 36, stalled by m_axis_tready
// front and back are split by a two-entry command queue; input stalls only when full
// async reset clears stored id, parse state and queue without waiting for a cycle
// ----------------------------------------------------------------------------
`include "uuid_text_codec_macros.svh"

module uuid_text_codec (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // text_char
    input  logic [1:0] s_axis_tuser,   // opcode
    input  logic       s_axis_tlast,   // char_last
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // out_char
    output logic [2:0] m_axis_tuser,   // parse_done, parse_ok, id_is_null
    output logic       m_axis_tlast    // out_last
);
    import utc_pkg::*;

    fifo_stat_t fifo_stat;
    cmd_t       push_cmd;
    cmd_t       head_cmd;
    logic       push;
    logic       pop;

    utc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .fifo_stat     (fifo_stat),
        .push          (push),
        .push_cmd      (push_cmd)
    );

    utc_cmd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .head_cmd  (head_cmd),
        .fifo_stat (fifo_stat)
    );

    utc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_cmd      (head_cmd),
        .fifo_stat     (fifo_stat),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    `UTC_ASSERT_NOW(a_no_overflow, push, !fifo_stat.full, "command pushed into full queue")
    `UTC_ASSERT_NOW(a_no_underflow, pop, !fifo_stat.empty, "command popped from empty queue")
    `UTC_ASSERT_NOW(a_ok_is_done, m_axis_tvalid && m_axis_tuser[1],
        m_axis_tuser[0] && m_axis_tlast && (m_axis_tdata == 8'h00),
        "parse ok outside a parse end word")
    `UTC_ASSERT_NEXT(a_clear_null, pop && (head_cmd.kind == CMD_CLEAR),
        m_axis_tvalid && m_axis_tuser[2] && m_axis_tlast,
        "clear word does not report null id")

endmodule
